@@ rtl/hit_pkg.sv @@
// Package for the hashed identity tracker: constants, types and the hash step.
package hit_pkg;

  localparam int TABLE_SLOTS = 64;
  localparam int SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [31:0] HASH_BASIS = 32'h811c9dc5;
  localparam logic [31:0] HASH_PRIME = 32'h01000193;

  typedef struct packed {
    logic [31:0] hash;
    logic [31:0] seconds;
  } lookup_t;

  typedef struct packed {
    logic [31:0] hash;
    logic [31:0] sessions;
    logic [31:0] first_time;
  } slot_entry_t;

  typedef struct packed {
    logic [31:0] identity_hash;
    logic [5:0]  slot_index;
    logic        is_new;
    logic        evicted;
    logic [31:0] slot_sessions;
    logic [31:0] slot_entry_time;
    logic [6:0]  live_unique;
    logic [31:0] all_time_unique;
    logic [31:0] eviction_total;
  } result_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_FETCH,
    BK_UPDATE
  } back_state_t;

  function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] b);
    logic [31:0] x;
    x = h ^ {24'd0, b};
    return 32'(x * HASH_PRIME);
  endfunction

endpackage

@@ rtl/hit_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module hit_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                        clk,
  input  logic                                        wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                            wr_data,
  input  logic                                        rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                            rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/hit_front.sv @@
// Front end: folds bytes into the running FNV-1a hash, queues finished lookups.
module hit_front
  import hit_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  identity_byte,
  input  logic        last_byte,
  input  logic [31:0] current_seconds,
  output logic        push_valid,
  output lookup_t     push_item,
  input  logic        push_ready
);
  logic [31:0] running_hash_r;
  logic [31:0] hash_nxt;
  logic        accept;

  assign in_tready = push_ready;
  assign accept    = in_tvalid && push_ready;
  assign hash_nxt  = fnv_step(running_hash_r, identity_byte);

  assign push_valid        = accept && last_byte;
  assign push_item.hash    = hash_nxt;
  assign push_item.seconds = current_seconds;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_hash_r <= HASH_BASIS;
    end else if (accept) begin
      running_hash_r <= last_byte ? HASH_BASIS : hash_nxt;
    end
  end

endmodule

@@ rtl/hit_queue.sv @@
// Short FIFO of finished hashes between the front end and the table engine.
module hit_queue
  import hit_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push_valid,
  input  lookup_t push_item,
  output logic    push_ready,
  output logic    pop_valid,
  output lookup_t pop_item,
  input  logic    pop
);
  lookup_t             entries_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QCNT_W-1:0]   count_r;
  logic                do_push;
  logic                do_pop;

  assign push_ready = count_r != QCNT_W'(QUEUE_DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_item   = entries_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

@@ rtl/hit_back.sv @@
// Table engine: scans the slot table, updates the matched or filled slot, holds the result.
module hit_back
  import hit_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    q_valid,
  input  lookup_t q_item,
  output logic    q_pop,
  output logic    out_tvalid,
  input  logic    out_tready,
  output result_t out_result
);
  back_state_t       state_r, state_nxt;
  logic [SLOT_W-1:0] scan_addr_r;
  logic              cmp_valid_r;
  logic [SLOT_W-1:0] cmp_addr_r;
  logic              empty_found_r;
  logic [SLOT_W-1:0] empty_addr_r;
  logic [SLOT_W-1:0] idx_r;
  logic              hit_r;
  logic              evict_r;
  logic              fetch_valid_r;
  logic [TABLE_SLOTS-1:0] valid_r;
  logic [6:0]        live_r;
  logic [31:0]       insert_total_r;
  logic [31:0]       evict_total_r;
  logic              out_tvalid_r;
  result_t           out_result_r;

  slot_entry_t       rd_entry;
  slot_entry_t       cur_entry;
  slot_entry_t       wr_entry;
  logic [31:0]       scan_hash;
  logic              match;
  logic              is_empty;
  logic              last_cmp;
  logic              advance;
  logic              ram_re;
  logic [SLOT_W-1:0] ram_rd_addr;
  logic [31:0]       new_sessions;

  hit_ram #(
    .WIDTH($bits(slot_entry_t)),
    .DEPTH(TABLE_SLOTS)
  ) u_slots (
    .clk     (clk),
    .wr_en   (advance),
    .wr_addr (idx_r),
    .wr_data (wr_entry),
    .rd_en   (ram_re),
    .rd_addr (ram_rd_addr),
    .rd_data (rd_entry)
  );

  // unwritten slots read as empty
  assign scan_hash = valid_r[cmp_addr_r] ? rd_entry.hash : '0;
  assign match     = cmp_valid_r && (scan_hash == q_item.hash);
  assign is_empty  = cmp_valid_r && (scan_hash == '0);
  assign last_cmp  = cmp_valid_r && (cmp_addr_r == SLOT_W'(TABLE_SLOTS - 1));
  assign advance   = (state_r == BK_UPDATE) && (!out_tvalid_r || out_tready);

  assign cur_entry    = fetch_valid_r ? rd_entry : '0;
  assign new_sessions = hit_r ? cur_entry.sessions + 32'd1 : 32'd1;

  always_comb begin
    wr_entry.sessions = new_sessions;
    if (hit_r) begin
      wr_entry.hash       = cur_entry.hash;
      wr_entry.first_time = cur_entry.first_time;
    end else begin
      wr_entry.hash       = q_item.hash;
      wr_entry.first_time = q_item.seconds;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE:   if (q_valid) state_nxt = BK_SCAN;
      BK_SCAN:   if (match || last_cmp) state_nxt = BK_FETCH;
      BK_FETCH:  state_nxt = BK_UPDATE;
      BK_UPDATE: if (advance) state_nxt = BK_IDLE;
      default:   state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    ram_re      = 1'b0;
    ram_rd_addr = scan_addr_r;
    case (state_r)
      BK_SCAN: begin
        ram_re = 1'b1;
      end
      BK_FETCH: begin
        ram_re      = 1'b1;
        ram_rd_addr = idx_r;
      end
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (state_r)
      BK_IDLE: begin
        scan_addr_r <= '0;
      end
      BK_SCAN: begin
        if (scan_addr_r != SLOT_W'(TABLE_SLOTS - 1)) begin
          scan_addr_r <= scan_addr_r + 1'b1;
        end
        cmp_addr_r <= scan_addr_r;
        if (is_empty && !empty_found_r) begin
          empty_addr_r <= cmp_addr_r;
        end
        if (match) begin
          idx_r   <= cmp_addr_r;
          hit_r   <= 1'b1;
          evict_r <= 1'b0;
        end else if (last_cmp) begin
          hit_r   <= 1'b0;
          idx_r   <= empty_found_r ? empty_addr_r : (is_empty ? cmp_addr_r : '0);
          evict_r <= !empty_found_r && !is_empty;
        end
      end
      BK_FETCH: begin
        fetch_valid_r <= valid_r[idx_r];
      end
      default: begin
      end
    endcase
    if (advance) begin
      out_result_r.identity_hash   <= q_item.hash;
      out_result_r.slot_index      <= 6'(idx_r);
      out_result_r.is_new          <= !hit_r;
      out_result_r.evicted         <= evict_r;
      out_result_r.slot_sessions   <= new_sessions;
      out_result_r.slot_entry_time <= wr_entry.first_time;
      out_result_r.live_unique     <= (!hit_r && !evict_r) ? live_r + 7'd1 : live_r;
      out_result_r.all_time_unique <= hit_r ? insert_total_r : insert_total_r + 32'd1;
      out_result_r.eviction_total  <= evict_r ? evict_total_r + 32'd1 : evict_total_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= BK_IDLE;
      cmp_valid_r    <= 1'b0;
      empty_found_r  <= 1'b0;
      valid_r        <= '0;
      live_r         <= '0;
      insert_total_r <= '0;
      evict_total_r  <= '0;
      out_tvalid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == BK_SCAN) begin
        cmp_valid_r <= 1'b1;
        if (is_empty) begin
          empty_found_r <= 1'b1;
        end
      end else begin
        cmp_valid_r   <= 1'b0;
        if (state_r == BK_IDLE) begin
          empty_found_r <= 1'b0;
        end
      end
      if (advance) begin
        valid_r[idx_r] <= 1'b1;
        if (!hit_r) begin
          insert_total_r <= insert_total_r + 32'd1;
          if (evict_r) begin
            evict_total_r <= evict_total_r + 32'd1;
          end else begin
            live_r <= live_r + 7'd1;
          end
        end
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  assign q_pop      = advance;
  assign out_tvalid = out_tvalid_r;
  assign out_result = out_result_r;

  a_update_exit: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> state_r == BK_IDLE)
    else $error("update did not return to idle");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_FETCH || state_r == BK_UPDATE) |-> !(hit_r && evict_r))
    else $error("hit and eviction at once");

  a_out_from_update: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r == BK_UPDATE))
    else $error("result raised outside update");

  a_pop_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != BK_IDLE) |-> q_valid)
    else $error("lookup in progress without a queued item");

endmodule

@@ rtl/hashed_identity_tracker_unit.sv @@
// Top level of the hashed identity tracker: stream ports around front, queue and table engine.
//
// Input channel (in_): one identity byte per item, in_tlast on the final byte of an
// identity, current time in seconds alongside. Non-final bytes are taken one per cycle
// while the queue has room, and only fold into the running FNV-1a hash; they produce no
// result. A final byte finishes the hash and queues a lookup (two-entry queue). The table
// engine scans the 64 slots one per cycle through a single RAM read port, then reads and
// writes the chosen slot; the time a lookup takes is set by how far the scan runs: to the
// first matching slot, or through the whole table on a miss. The engine works on one
// lookup at a time; once the queue is full, no byte is taken until a lookup completes.
// Result channel (out_): one item per identity, held in an output register; while the
// receiver stalls the engine finishes its next lookup and waits, and the front keeps
// taking bytes until the queue is full, then drops in_tready.
// Reset: running hash to the offset basis, all slots read as empty through per-slot
// valid bits (no clearing pass), all counters zero. Block is ready the cycle after reset.
module hashed_identity_tracker_unit
  import hit_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [39:0]  in_tdata,   // identity_byte[7:0], current_seconds[39:8]
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  // identity_hash[31:0], slot_index[37:32], slot_sessions[69:38], slot_entry_time[101:70],
  // live_unique[108:102], all_time_unique[140:109], eviction_total[172:141], zero pad
  output logic [175:0] out_tdata,
  output logic [1:0]   out_tuser   // is_new[0], evicted[1]
);
  logic    push_valid;
  lookup_t push_item;
  logic    push_ready;
  logic    q_valid;
  lookup_t q_item;
  logic    q_pop;
  result_t res;

  hit_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .identity_byte   (in_tdata[7:0]),
    .last_byte       (in_tlast),
    .current_seconds (in_tdata[39:8]),
    .push_valid      (push_valid),
    .push_item       (push_item),
    .push_ready      (push_ready)
  );

  hit_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop_valid  (q_valid),
    .pop_item   (q_item),
    .pop        (q_pop)
  );

  hit_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_result (res)
  );

  assign out_tdata = {3'd0, res.eviction_total, res.all_time_unique, res.live_unique,
                      res.slot_entry_time, res.slot_sessions, res.slot_index,
                      res.identity_hash};
  assign out_tuser = {res.evicted, res.is_new};

endmodule

@@ dv/hashed_identity_tracker_unit_tb.sv @@
// Testbench for hashed_identity_tracker_unit: random byte streams checked against an FNV-1a table model.
`timescale 1ns / 100ps

module hashed_identity_tracker_unit_tb
  import hit_pkg::*;
();

  typedef struct packed {
    logic [4:0]   len;
    logic [127:0] bytes;
  } identity_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [39:0]  in_tdata = '0;    // identity_byte[7:0], current_seconds[39:8]
  logic         in_tlast = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [175:0] out_tdata;        // hash, slot, sessions, entry time, live, inserts, evicts
  logic [1:0]   out_tuser;        // is_new[0], evicted[1]

  hashed_identity_tracker_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  // table model
  logic [31:0] running_hash = HASH_BASIS;
  logic [31:0] slot_hash      [TABLE_SLOTS];
  logic [31:0] slot_sessions  [TABLE_SLOTS];
  logic [31:0] slot_first     [TABLE_SLOTS];
  logic [6:0]  live_count;
  logic [31:0] insert_count;
  logic [31:0] evict_count;
  result_t     pending_results[$];

  identity_t   identity_pool[$];
  identity_t   zero_hash_identity;
  bit          have_zero_hash = 1'b0;
  logic [16:0] prefix_by_hash [bit [31:0]];

  bit sender_idle = 1'b0;
  bit receiver_idle = 1'b0;
  int stall_left = 0;
  int mismatches = 0;
  int bytes_sent = 0;
  int lookups_checked = 0;
  int hit_lookups = 0;
  int zero_hash_lookups = 0;

  function automatic void lookup_identity(input logic [7:0] b, input logic last,
                                          input logic [31:0] secs);
    logic [31:0] h;
    int          idx;
    int          i;
    result_t     r;
    h = 32'((running_hash ^ {24'd0, b}) * HASH_PRIME);
    if (!last) begin
      running_hash = h;
      return;
    end
    running_hash = HASH_BASIS;
    r = '0;
    idx = -1;
    for (i = 0; i < TABLE_SLOTS; i++)
      if (idx < 0 && slot_hash[i] == h) idx = i;
    if (h == 32'd0) zero_hash_lookups++;
    if (idx >= 0) begin
      slot_sessions[idx] = slot_sessions[idx] + 32'd1;
      hit_lookups++;
    end else begin
      for (i = 0; i < TABLE_SLOTS; i++)
        if (idx < 0 && slot_hash[i] == 32'd0) idx = i;
      if (idx < 0) begin
        idx = 0;
        r.evicted = 1'b1;
        evict_count = evict_count + 32'd1;
        live_count = live_count - 7'd1;
      end
      slot_hash[idx] = h;
      slot_first[idx] = secs;
      slot_sessions[idx] = 32'd1;
      live_count = live_count + 7'd1;
      insert_count = insert_count + 32'd1;
      r.is_new = 1'b1;
    end
    r.identity_hash   = h;
    r.slot_index      = idx[5:0];
    r.slot_sessions   = slot_sessions[idx];
    r.slot_entry_time = slot_first[idx];
    r.live_unique     = live_count;
    r.all_time_unique = insert_count;
    r.eviction_total  = evict_count;
    pending_results.push_back(r);
  endfunction

  task automatic send_item(input logic [7:0] b, input logic last, input logic [31:0] secs);
    int gap;
    gap = sender_idle ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {secs, b};
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    lookup_identity(b, last, secs);
    bytes_sent++;
  endtask

  task automatic send_identity(input identity_t id, input logic [31:0] secs);
    int i;
    for (i = 0; i < id.len; i++)
      send_item(id.bytes[8*i +: 8], i == id.len - 1, (i == id.len - 1) ? secs : $urandom);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic identity_t random_identity();
    identity_t id;
    id.len = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(7, 16)) : 5'($urandom_range(1, 6));
    id.bytes = {$urandom, $urandom, $urandom, $urandom};
    return id;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      stall_left = receiver_idle ? $urandom_range(0, 8) : 0;
      if (pending_results.size() == 0) begin
        $error("unexpected result item, hash %0h", out_tdata[31:0]);
        mismatches++;
      end else begin
        exp_r = pending_results.pop_front();
        check_field("identity_hash", exp_r.identity_hash, out_tdata[31:0]);
        check_field("slot_index", 32'(exp_r.slot_index), 32'(out_tdata[37:32]));
        check_field("is_new", 32'(exp_r.is_new), 32'(out_tuser[0]));
        check_field("evicted", 32'(exp_r.evicted), 32'(out_tuser[1]));
        check_field("slot_sessions", exp_r.slot_sessions, out_tdata[69:38]);
        check_field("slot_entry_time", exp_r.slot_entry_time, out_tdata[101:70]);
        check_field("live_unique", 32'(exp_r.live_unique), 32'(out_tdata[108:102]));
        check_field("all_time_unique", exp_r.all_time_unique, out_tdata[140:109]);
        check_field("eviction_total", exp_r.eviction_total, out_tdata[172:141]);
        lookups_checked++;
      end
    end
  end

  // field extremes, short identities, repeat hits
  task automatic test_single_and_repeat();
    identity_t id;
    id.bytes = '0;
    id.len = 5'd1;
    send_identity(id, 32'd0);
    id.bytes[7:0] = 8'hff;
    send_identity(id, 32'hffffffff);
    id.len = 5'd3;
    id.bytes[23:0] = 24'h636261;
    send_identity(id, 32'h12345678);
    send_identity(id, 32'h0);
    id.len = 5'd4;
    id.bytes[31:0] = 32'h00ff00ff;
    send_identity(id, 32'h80000001);
    id.len = 5'd1;
    id.bytes[7:0] = 8'h00;
    send_identity(id, 32'h7fffffff);
  endtask

  // identity whose hash is zero, found by meet-in-the-middle on the FNV-1a inverse
  task automatic test_zero_hash();
    logic [31:0] prime_inv;
    logic [31:0] h1;
    logic [31:0] h2;
    logic [31:0] h3;
    logic [31:0] s_val;
    logic [31:0] t_val;
    logic [16:0] pre;
    int f1, f2, f3, l, b1, b2;
    prime_inv = HASH_PRIME;
    repeat (5) prime_inv = 32'(prime_inv * 32'(32'd2 - 32'(HASH_PRIME * prime_inv)));
    for (f1 = 0; f1 < 256; f1++) begin
      h1 = 32'((HASH_BASIS ^ 32'(f1)) * HASH_PRIME);
      for (f2 = 0; f2 < 256; f2++) begin
        h2 = 32'((h1 ^ 32'(f2)) * HASH_PRIME);
        for (f3 = 0; f3 < 2; f3++) begin
          h3 = 32'((h2 ^ 32'(f3)) * HASH_PRIME);
          prefix_by_hash[h3] = {f3[0], f2[7:0], f1[7:0]};
        end
      end
    end
    for (l = 0; l < 256 && !have_zero_hash; l++)
      for (b1 = 0; b1 < 256 && !have_zero_hash; b1++) begin
        s_val = 32'(32'(l) * prime_inv) ^ 32'(b1);
        for (b2 = 0; b2 < 4 && !have_zero_hash; b2++) begin
          t_val = 32'(s_val * prime_inv) ^ 32'(b2);
          if (prefix_by_hash.exists(t_val)) begin
            pre = prefix_by_hash[t_val];
            zero_hash_identity.len = 5'd6;
            zero_hash_identity.bytes = '0;
            zero_hash_identity.bytes[47:0] = {l[7:0], b1[7:0], b2[7:0], 7'd0, pre};
            have_zero_hash = 1'b1;
          end
        end
      end
    prefix_by_hash.delete();
    if (!have_zero_hash) begin
      $error("no zero-hash identity found");
      mismatches++;
    end else begin
      send_identity(zero_hash_identity, 32'hdeadbeef);
      send_identity(zero_hash_identity, 32'h00000001);
    end
  endtask

  // fill the table, evict slot 0, zero hash on a full table
  task automatic test_table_overflow();
    identity_t id;
    int n;
    sender_idle = 1'b1;
    receiver_idle = 1'b1;
    for (n = 0; n < 80; n++) begin
      id = random_identity();
      id.len = 5'($urandom_range(1, 3));
      identity_pool.push_back(id);
      send_identity(id, $urandom);
    end
    if (have_zero_hash) send_identity(zero_hash_identity, $urandom);
    for (n = 0; n < 4; n++) begin
      id = random_identity();
      identity_pool.push_back(id);
      send_identity(id, $urandom);
    end
    for (n = 0; n < 6; n++)
      send_identity(identity_pool[$urandom_range(0, identity_pool.size() - 1)], $urandom);
  endtask

  task automatic test_random_traffic();
    identity_t id;
    int start_bytes;
    int n;
    int sel;
    start_bytes = bytes_sent;
    n = 0;
    while (bytes_sent < start_bytes + 1300) begin
      if (n % 40 == 0) begin
        sender_idle = 1'($urandom_range(0, 1));
        receiver_idle = 1'($urandom_range(0, 1));
      end
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
        id = identity_pool[$urandom_range(0, identity_pool.size() - 1)];
      end else if (sel < 48 && have_zero_hash) begin
        id = zero_hash_identity;
      end else begin
        id = random_identity();
        identity_pool.push_back(id);
      end
      send_identity(id, $urandom);
      n++;
    end
  endtask

  initial begin
    int i;
    for (i = 0; i < TABLE_SLOTS; i++) begin
      slot_hash[i] = '0;
      slot_sessions[i] = '0;
      slot_first[i] = '0;
    end
    live_count = '0;
    insert_count = '0;
    evict_count = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_single_and_repeat();
    test_zero_hash();
    wait_drained();
    test_table_overflow();
    test_random_traffic();

    wait_drained();
    repeat (80) @(posedge clk);
    $display("Sent %0d bytes; checked %0d lookups: %0d hits, %0d zero-hash.",
             bytes_sent, lookups_checked, hit_lookups, zero_hash_lookups);
    $display("Insertions %0d, evictions %0d, live %0d at end.",
             insert_count, evict_count, live_count);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
